// ===== sv/mrfe_pkg.sv =====
`timescale 1ns / 1ps

package mrfe_pkg;

	// Sizing of the framer.
	localparam int MAX_FRAME  = 256;
	localparam int TIMER_BITS = 16;

	localparam int RXC_W = $clog2(MAX_FRAME + 1);
	localparam int TXC_W = $clog2(MAX_FRAME - 1);
	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam int CFG_IDX_W = 1;
	localparam int MAX_RESULTS = 3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] T15_RESET = 16'd1432;
	localparam logic [15:0] T35_RESET = 16'd2578;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_T15 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_T35 = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_RX_BYTE = 2'd1,
		OP_RX_ERR  = 2'd2,
		OP_TX_BYTE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		MODE_INIT      = 3'd0,
		MODE_IDLE      = 3'd1,
		MODE_RECEPTION = 3'd2,
		MODE_CTRL_WAIT = 3'd3,
		MODE_EMISSION  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_RX_BYTE  = 3'd0,
		KIND_STATUS   = 3'd1,
		KIND_TX_BYTE  = 3'd2,
		KIND_READY    = 3'd3,
		KIND_REJECTED = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_TOO_SHORT = 2'd1,
		STAT_CRC_BAD   = 2'd2
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] byte_value;
		logic       end_of_message;
	} cmd_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] position;
		status_t    frame_status;
		logic [7:0] payload_length;
		logic       run_end;
	} res_t;

	// The words that one item produces, first word in slot 0.
	typedef struct packed {
		logic [1:0]                  count;
		res_t [MAX_RESULTS-1:0]      word;
	} batch_t;

	// One byte of CRC-16/Modbus, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic res_t mk_res(input kind_t kind, input logic [7:0] data,
		input logic [7:0] pos, input status_t status, input logic [7:0] len,
		input logic last);
		res_t r;
		r.kind           = kind;
		r.data_byte      = data;
		r.position       = pos;
		r.frame_status   = status;
		r.payload_length = len;
		r.run_end        = last;
		return r;
	endfunction

endpackage

// ===== sv/mrfe_cmd_if.sv =====
`timescale 1ns / 1ps

interface mrfe_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] byte_value;
	logic       end_of_message;

	modport source (output valid, op, byte_value, end_of_message, input ready);
	modport sink (input valid, op, byte_value, end_of_message, output ready);
endinterface

// ===== sv/mrfe_evt_if.sv =====
`timescale 1ns / 1ps

interface mrfe_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] data_byte;
	logic [7:0] position;
	logic [1:0] frame_status;
	logic [7:0] payload_length;
	logic       run_end;

	modport source (output valid, kind, data_byte, position, frame_status,
		payload_length, run_end, input ready);
	modport sink (input valid, kind, data_byte, position, frame_status,
		payload_length, run_end, output ready);
endinterface

// ===== sv/mrfe_cfg_if.sv =====
`timescale 1ns / 1ps

interface mrfe_cfg_if import mrfe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/mrfe_engine.sv =====
`timescale 1ns / 1ps

module mrfe_engine import mrfe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	mrfe_cmd_if.sink     cmd,
	mrfe_cfg_if.sink     cfg,
	input  logic         buf_free,
	output logic         fire,
	output batch_t       batch
);

	// Input register.
	logic vld_s1;
	cmd_t cmd_s1;

	// Framer state.
	mode_t                 mode_q, mode_n;
	logic [TIMER_BITS-1:0] timer_q, timer_n;
	logic [RXC_W-1:0]      rx_count_q, rx_count_n;
	logic [7:0]            hold0_q, hold0_n, hold1_q, hold1_n;
	logic [15:0]           rx_crc_q, rx_crc_n;
	logic [15:0]           tx_crc_q, tx_crc_n;
	logic [TXC_W-1:0]      tx_count_q, tx_count_n;
	logic [15:0]           t15_q, t35_q;

	// Helper values.
	logic [TIMER_BITS-1:0] t_inc;
	logic                  hit15, hit35;
	logic [RXC_W-1:0]      rx_next;
	logic [15:0]           rx_crc_upd;
	logic [15:0]           tx_base_crc, tx_crc_upd;
	logic [TXC_W-1:0]      tx_base_cnt;
	logic [TXC_W:0]        tx_next;
	logic                  tx_last;
	status_t               rx_status;
	logic [7:0]            rx_len;
	logic                  rx_short;

	// The item in the input register is worked on once the result buffer has room.
	assign fire      = vld_s1 & buf_free;
	assign cmd.ready = ~vld_s1 | fire;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.op             <= op_t'(cmd.op);
			cmd_s1.byte_value     <= cmd.byte_value;
			cmd_s1.end_of_message <= cmd.end_of_message;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t15_q <= T15_RESET;
			t35_q <= T35_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_T15: t15_q <= cfg.data;
				CFG_T35: t35_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Saturating gap timer and its thresholds.
	assign t_inc = (&timer_q) ? timer_q : timer_q + 1'b1;
	assign hit15 = CMP_W'(t_inc) >= CMP_W'(t15_q);
	assign hit35 = CMP_W'(t_inc) >= CMP_W'(t35_q);

	// Receive side: the oldest held byte enters the CRC when it is forwarded.
	assign rx_next    = rx_count_q + 1'b1;
	assign rx_crc_upd = crc16_byte(rx_crc_q, hold0_q);
	assign rx_short   = rx_count_q < RXC_W'(4);
	assign rx_len     = rx_short ? 8'd0 : 8'(rx_count_q - RXC_W'(4));
	assign rx_status  = rx_short ? STAT_TOO_SHORT :
		(({hold1_q, hold0_q} == rx_crc_q) ? STAT_OK : STAT_CRC_BAD);

	// Send side: a message starting from idle begins with a fresh CRC.
	assign tx_base_crc = (mode_q == MODE_IDLE) ? CRC_INIT : tx_crc_q;
	assign tx_base_cnt = (mode_q == MODE_IDLE) ? '0 : tx_count_q;
	assign tx_crc_upd  = crc16_byte(tx_base_crc, cmd_s1.byte_value);
	assign tx_next     = {1'b0, tx_base_cnt} + 1'b1;
	assign tx_last     = cmd_s1.end_of_message | (tx_next >= (TXC_W + 1)'(MAX_FRAME - 2));

	// Next state and result words for the item in the input register.
	always_comb begin
		mode_n     = mode_q;
		timer_n    = timer_q;
		rx_count_n = rx_count_q;
		hold0_n    = hold0_q;
		hold1_n    = hold1_q;
		rx_crc_n   = rx_crc_q;
		tx_crc_n   = tx_crc_q;
		tx_count_n = tx_count_q;
		batch      = '0;
		unique case (cmd_s1.op)
			OP_TICK: begin
				if (mode_q == MODE_INIT) begin
					timer_n = t_inc;
					if (hit35) begin
						mode_n     = MODE_IDLE;
						timer_n    = '0;
						rx_count_n = '0;
						hold0_n    = 8'd0;
						hold1_n    = 8'd0;
						rx_crc_n   = CRC_INIT;
						batch.count   = 2'd1;
						batch.word[0] = mk_res(KIND_READY, 8'd0, 8'd0, STAT_OK, 8'd0, 1'b1);
					end
				end else if (mode_q == MODE_RECEPTION || mode_q == MODE_CTRL_WAIT) begin
					timer_n = t_inc;
					if (mode_q == MODE_RECEPTION && hit15) begin
						mode_n = MODE_CTRL_WAIT;
					end
					// Frame check once the line has been quiet for T3.5.
					if ((mode_q == MODE_CTRL_WAIT || hit15) && hit35) begin
						mode_n     = MODE_IDLE;
						timer_n    = '0;
						rx_count_n = '0;
						hold0_n    = 8'd0;
						hold1_n    = 8'd0;
						rx_crc_n   = CRC_INIT;
						batch.count   = 2'd1;
						batch.word[0] = mk_res(KIND_STATUS, 8'd0, 8'd0, rx_status, rx_len,
							1'b1);
					end
				end
			end
			OP_RX_BYTE: begin
				if (mode_q == MODE_INIT) begin
					timer_n = '0;
				end else if (mode_q == MODE_IDLE || mode_q == MODE_RECEPTION) begin
					mode_n     = (rx_next >= RXC_W'(MAX_FRAME)) ? MODE_CTRL_WAIT :
						MODE_RECEPTION;
					timer_n    = '0;
					rx_count_n = rx_next;
					if (rx_count_q >= RXC_W'(2)) begin
						// Forward the byte received two bytes ago.
						rx_crc_n = rx_crc_upd;
						hold0_n  = hold1_q;
						hold1_n  = cmd_s1.byte_value;
						batch.count   = 2'd1;
						batch.word[0] = mk_res(KIND_RX_BYTE, hold0_q,
							8'(rx_count_q - RXC_W'(2)), STAT_OK, 8'd0, 1'b1);
					end else if (rx_count_q[0]) begin
						hold1_n = cmd_s1.byte_value;
					end else begin
						hold0_n = cmd_s1.byte_value;
					end
				end
			end
			OP_RX_ERR: begin
				if (mode_q == MODE_IDLE || mode_q == MODE_RECEPTION) begin
					mode_n     = MODE_IDLE;
					timer_n    = '0;
					rx_count_n = '0;
					hold0_n    = 8'd0;
					hold1_n    = 8'd0;
					rx_crc_n   = CRC_INIT;
				end
			end
			OP_TX_BYTE: begin
				if (mode_q == MODE_IDLE || mode_q == MODE_EMISSION) begin
					batch.word[0] = mk_res(KIND_TX_BYTE, cmd_s1.byte_value, 8'd0, STAT_OK,
						8'd0, ~tx_last);
					if (tx_last) begin
						// Append the CRC, low byte first.
						batch.count   = 2'd3;
						batch.word[1] = mk_res(KIND_TX_BYTE, tx_crc_upd[7:0], 8'd0, STAT_OK,
							8'd0, 1'b0);
						batch.word[2] = mk_res(KIND_TX_BYTE, tx_crc_upd[15:8], 8'd0,
							STAT_OK, 8'd0, 1'b1);
						mode_n     = MODE_IDLE;
						timer_n    = '0;
						rx_count_n = '0;
						hold0_n    = 8'd0;
						hold1_n    = 8'd0;
						rx_crc_n   = CRC_INIT;
						tx_count_n = '0;
						tx_crc_n   = CRC_INIT;
					end else begin
						batch.count = 2'd1;
						mode_n      = MODE_EMISSION;
						tx_count_n  = tx_next[TXC_W-1:0];
						tx_crc_n    = tx_crc_upd;
					end
				end else begin
					batch.count   = 2'd1;
					batch.word[0] = mk_res(KIND_REJECTED, 8'd0, 8'd0, STAT_OK, 8'd0, 1'b1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_INIT;
			timer_q    <= '0;
			rx_count_q <= '0;
			hold0_q    <= 8'd0;
			hold1_q    <= 8'd0;
			rx_crc_q   <= CRC_INIT;
			tx_crc_q   <= CRC_INIT;
			tx_count_q <= '0;
		end else if (fire) begin
			mode_q     <= mode_n;
			timer_q    <= timer_n;
			rx_count_q <= rx_count_n;
			hold0_q    <= hold0_n;
			hold1_q    <= hold1_n;
			rx_crc_q   <= rx_crc_n;
			tx_crc_q   <= tx_crc_n;
			tx_count_q <= tx_count_n;
		end
	end

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (rx_count_q == '0 && rx_crc_q == CRC_INIT))
		else $error("idle with a partial frame");
	a_tx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_EMISSION) |-> (tx_count_q == '0))
		else $error("send count left over outside emission");
	a_tx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_EMISSION) |-> (tx_count_q != '0 &&
		{1'b0, tx_count_q} < (TXC_W + 1)'(MAX_FRAME - 2)))
		else $error("send count out of range");
`endif

endmodule

// ===== sv/mrfe_res_buf.sv =====
`timescale 1ns / 1ps

module mrfe_res_buf import mrfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  batch_t     batch,
	output logic       free,
	mrfe_evt_if.source evt
);

	res_t [MAX_RESULTS-1:0] slot_q;
	logic [1:0]             cnt_q;
	logic                   pop;

	// The head word is always slot 0; a pop shifts the rest down.
	assign pop  = evt.valid & evt.ready;
	assign free = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & pop);

	assign evt.valid          = cnt_q != 2'd0;
	assign evt.kind           = slot_q[0].kind;
	assign evt.data_byte      = slot_q[0].data_byte;
	assign evt.position       = slot_q[0].position;
	assign evt.frame_status   = slot_q[0].frame_status;
	assign evt.payload_length = slot_q[0].payload_length;
	assign evt.run_end        = slot_q[0].run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q <= batch.word;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> free)
		else $error("result words overwritten");
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> slot_q[0].run_end)
		else $error("last buffered word does not close its run");
`endif

endmodule

// ===== sv/modbus_rtu_frame_engine_core.sv =====
`timescale 1ns / 1ps

// Modbus RTU line framer.
// Channels: cmd takes one word per tick, line byte, line error or byte to
// send (valid/ready). evt gives result words (valid/ready): forwarded frame
// bytes, frame status, line bytes to send, ready after init, send rejects.
// The words of one cmd word end with run_end set. cfg writes the T1.5 and
// T3.5 tick counts (index 0 and 1) and is always ready; it must be written
// only while no cmd word is in flight, which the block does not enforce.
// A result word of a cmd word passes the input register and then the
// result buffer before it is offered on evt.
// Throughput: one cmd word per cycle while evt takes each word as offered
// and each cmd word produces at most one result word; the last byte of a
// message produces three words, and the next cmd word waits in the input
// register until the last of them leaves, which frees the result buffer.
// Reset: the framer starts in init and reports ready after T3.5 quiet ticks;
// the thresholds return to 1432 and 2578 ticks.
// When evt stalls, up to three words wait in the buffer, one cmd word waits
// in the input register, and cmd.ready drops until room appears.

module modbus_rtu_frame_engine_core import mrfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mrfe_cmd_if.sink   cmd,
	mrfe_evt_if.source evt,
	mrfe_cfg_if.sink   cfg
);

	logic   buf_free;
	logic   fire;
	batch_t batch;

	// Input register, framer state and step logic.
	mrfe_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.buf_free (buf_free),
		.fire     (fire),
		.batch    (batch)
	);

	// Result words toward the receiver.
	mrfe_res_buf u_res_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.batch  (batch),
		.free   (buf_free),
		.evt    (evt)
	);

endmodule

// ===== test/modbus_rtu_frame_engine_core_tb.sv =====
`timescale 1ns / 1ps

import mrfe_pkg::*;

// Tracks the framer's state and checks every result word against it.
class frame_scoreboard;
	logic [15:0]           t15_limit;
	logic [15:0]           t35_limit;
	mode_t                 mode;
	logic [TIMER_BITS-1:0] gap;
	int unsigned           rx_count;
	logic [7:0]            held[2];
	logic [15:0]           rx_crc;
	logic [15:0]           tx_crc;
	int unsigned           tx_count;
	res_t                  pending_words[$];
	int unsigned           errors;
	int unsigned           words_seen;
	int unsigned           n_ok;
	int unsigned           n_short;
	int unsigned           n_bad;
	int unsigned           n_messages;
	int unsigned           n_refused;

	function new();
		t15_limit = T15_RESET;
		t35_limit = T35_RESET;
		drop_frame();
		mode = MODE_INIT;
		tx_crc = CRC_INIT;
		tx_count = 0;
	endfunction

	// CRC-16/Modbus, one data bit at a time, LSB first.
	function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function void drop_frame();
		mode = MODE_IDLE;
		gap = '0;
		rx_count = 0;
		held[0] = 8'h00;
		held[1] = 8'h00;
		rx_crc = CRC_INIT;
	endfunction

	function void add_word(kind_t k, logic [7:0] d, logic [7:0] p, status_t s,
		logic [7:0] l);
		res_t w;
		w.kind = k;
		w.data_byte = d;
		w.position = p;
		w.frame_status = s;
		w.payload_length = l;
		w.run_end = 1'b0;
		pending_words.push_back(w);
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		if (idx == CFG_T15) begin
			t15_limit = v;
		end else if (idx == CFG_T35) begin
			t35_limit = v;
		end
	endfunction

	function int pending();
		return pending_words.size();
	endfunction

	// Works out the words that one accepted command word causes.
	function void take_command(op_t op, logic [7:0] b, logic eom);
		int      before_n;
		logic    closing;
		status_t st;
		res_t    w;
		before_n = pending_words.size();
		closing = eom;
		case (op)
			OP_TICK: begin
				if (mode == MODE_INIT) begin
					if (~&gap) gap++;
					if (gap >= t35_limit) begin
						drop_frame();
						add_word(KIND_READY, 8'h00, 8'h00, STAT_OK, 8'h00);
					end
				end else if (mode == MODE_RECEPTION || mode == MODE_CTRL_WAIT) begin
					if (~&gap) gap++;
					if (mode == MODE_RECEPTION && gap >= t15_limit) mode = MODE_CTRL_WAIT;
					if (mode == MODE_CTRL_WAIT && gap >= t35_limit) begin
						if (rx_count < 4) begin
							add_word(KIND_STATUS, 8'h00, 8'h00, STAT_TOO_SHORT, 8'h00);
							n_short++;
						end else begin
							st = ({held[1], held[0]} == rx_crc) ? STAT_OK : STAT_CRC_BAD;
							if (st == STAT_OK) n_ok++;
							else n_bad++;
							add_word(KIND_STATUS, 8'h00, 8'h00, st, 8'(rx_count - 4));
						end
						drop_frame();
					end
				end
			end
			OP_RX_BYTE: begin
				if (mode == MODE_INIT) begin
					gap = '0;
				end else if (mode == MODE_IDLE || mode == MODE_RECEPTION) begin
					mode = MODE_RECEPTION;
					gap = '0;
					// Two bytes are held back so the CRC never gets forwarded.
					if (rx_count >= 2) begin
						add_word(KIND_RX_BYTE, held[0], 8'(rx_count - 2), STAT_OK, 8'h00);
						rx_crc = crc_next(rx_crc, held[0]);
						held[0] = held[1];
						held[1] = b;
					end else begin
						held[rx_count % 2] = b;
					end
					rx_count++;
					if (rx_count >= MAX_FRAME) mode = MODE_CTRL_WAIT;
				end
			end
			OP_RX_ERR: begin
				if (mode == MODE_IDLE || mode == MODE_RECEPTION) drop_frame();
			end
			default: begin
				if (mode == MODE_IDLE) begin
					mode = MODE_EMISSION;
					tx_count = 0;
					tx_crc = CRC_INIT;
				end
				if (mode == MODE_EMISSION) begin
					add_word(KIND_TX_BYTE, b, 8'h00, STAT_OK, 8'h00);
					tx_crc = crc_next(tx_crc, b);
					tx_count++;
					if (tx_count >= MAX_FRAME - 2) closing = 1'b1;
					if (closing) begin
						add_word(KIND_TX_BYTE, tx_crc[7:0], 8'h00, STAT_OK, 8'h00);
						add_word(KIND_TX_BYTE, tx_crc[15:8], 8'h00, STAT_OK, 8'h00);
						drop_frame();
						tx_count = 0;
						tx_crc = CRC_INIT;
						n_messages++;
					end
				end else begin
					add_word(KIND_REJECTED, 8'h00, 8'h00, STAT_OK, 8'h00);
					n_refused++;
				end
			end
		endcase
		if (pending_words.size() > before_n) begin
			w = pending_words.pop_back();
			w.run_end = 1'b1;
			pending_words.push_back(w);
		end
	endfunction

	function string show(res_t w);
		return $sformatf("kind %0d data %02h pos %0d status %0d len %0d end %0d",
			w.kind, w.data_byte, w.position, w.frame_status, w.payload_length, w.run_end);
	endfunction

	// Compares one accepted result word with the oldest expected word.
	function void check_word(res_t got);
		res_t want;
		words_seen++;
		if (pending_words.size() == 0) begin
			errors++;
			if (errors <= 10) $display("Unexpected word: %s", show(got));
			return;
		end
		want = pending_words.pop_front();
		if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
			got.position !== want.position || got.frame_status !== want.frame_status ||
			got.payload_length !== want.payload_length || got.run_end !== want.run_end) begin
			errors++;
			if (errors <= 10) begin
				$display("Word %0d mismatch: expected %s", words_seen, show(want));
				$display("                 actual   %s", show(got));
			end
		end
	endfunction
endclass

module modbus_rtu_frame_engine_core_tb;
	localparam int HALF_PERIOD  = 4;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_PCT     = 14;
	localparam int RANDOM_ITEMS = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        steady = 1'b0;
	logic        sink_ready = 1'b0;
	int unsigned hold_req = 0;
	int unsigned hold_ack = 0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;
	int unsigned n_items = 0;
	int unsigned n_active = 0;

	mrfe_cmd_if cmd();
	mrfe_evt_if evt();
	mrfe_cfg_if cfg();

	frame_scoreboard sb = new();

	modbus_rtu_frame_engine_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.evt    (evt),
		.cfg    (cfg)
	);

	assign evt.ready = sink_ready;

	always #(HALF_PERIOD) clk = ~clk;

	// Result side: checks each accepted word and stalls at random or on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else begin
			if (evt.valid && evt.ready) begin
				sb.check_word(res_t'({evt.kind, evt.data_byte, evt.position,
					evt.frame_status, evt.payload_length, evt.run_end}));
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_left <= HOLD_CYCLES;
				sink_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				sink_ready <= 1'b0;
			end else begin
				sink_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d words outstanding.",
				cycles, sb.pending());
			$display("modbus_rtu_frame_engine_core test failed");
			$finish;
		end
	end

	// Offers one command word, with random gaps ahead of it, and waits for it to be taken.
	task automatic send_cmd(op_t op, logic [7:0] b, logic eom);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				cmd.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.byte_value <= b;
		cmd.end_of_message <= eom;
		do @(posedge clk); while (!cmd.ready);
		sb.take_command(op, b, eom);
		n_items++;
		if (op != OP_TICK) n_active++;
	endtask

	task automatic ticks(int n);
		repeat (n) send_cmd(OP_TICK, 8'($urandom), 1'($urandom));
	endtask

	task automatic rx_raw(int n);
		repeat (n) send_cmd(OP_RX_BYTE, 8'($urandom), 1'($urandom));
	endtask

	// Sends a frame on the line with its CRC appended, optionally with one bit flipped.
	task automatic rx_data(input logic [7:0] frame_bytes[$], input bit corrupt);
		logic [15:0] c;
		int          k;
		c = CRC_INIT;
		foreach (frame_bytes[i]) c = sb.crc_next(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
		if (corrupt) begin
			k = $urandom_range(0, frame_bytes.size() - 1);
			frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		foreach (frame_bytes[i]) send_cmd(OP_RX_BYTE, frame_bytes[i], 1'($urandom));
	endtask

	task automatic rx_random(int n_data, bit corrupt);
		logic [7:0] q[$];
		repeat (n_data) q.push_back(8'($urandom));
		rx_data(q, corrupt);
	endtask

	task automatic tx_message(int len, bit mark_last);
		for (int i = 0; i < len; i++) begin
			send_cmd(OP_TX_BYTE, 8'($urandom), mark_last && (i == len - 1));
		end
	endtask

	// Drives the framer back to idle: ticks through init or a frame, or ends a message.
	task automatic settle();
		while (sb.mode != MODE_IDLE) begin
			if (sb.mode == MODE_EMISSION) send_cmd(OP_TX_BYTE, 8'($urandom), 1'b1);
			else ticks(1);
		end
	endtask

	// Lets every expected word drain, then keeps waiting so that words not yet due can show up.
	task automatic wait_quiet();
		cmd.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_timing(logic [15:0] t15, logic [15:0] t35);
		cfg.valid <= 1'b1;
		cfg.index <= CFG_T15;
		cfg.data <= t15;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(CFG_T15, t15);
		cfg.index <= CFG_T35;
		cfg.data <= t35;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(CFG_T35, t35);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_directed();
		logic [7:0] q[$];
		// During init a send is refused, a byte restarts the quiet count and an error is ignored.
		send_cmd(OP_TX_BYTE, 8'hA5, 1'b1);
		send_cmd(OP_RX_BYTE, 8'h11, 1'b0);
		send_cmd(OP_RX_ERR, 8'h00, 1'b0);
		ticks(100);
		send_cmd(OP_RX_BYTE, 8'h22, 1'b1);
		settle();

		// T3.5 equal to T1.5: one tick ends and checks a frame.
		wait_quiet();
		set_timing(16'd1, 16'd1);
		send_cmd(OP_TICK, 8'hFF, 1'b1);
		rx_raw(1);
		settle();
		rx_random(0, 1'b0);
		settle();
		rx_raw(3);
		settle();
		q = '{8'h00, 8'hFF};
		rx_data(q, 1'b0);
		settle();
		q = '{8'hFF, 8'h00, 8'h5A};
		rx_data(q, 1'b1);
		settle();
		// A line error drops a frame in progress, and is harmless in idle.
		rx_raw(3);
		send_cmd(OP_RX_ERR, 8'h00, 1'b0);
		send_cmd(OP_RX_ERR, 8'hFF, 1'b1);
		// A send during reception is refused.
		rx_raw(2);
		send_cmd(OP_TX_BYTE, 8'h3C, 1'b1);
		settle();
		// Single-byte message, then a message with line traffic mixed in.
		tx_message(1, 1'b1);
		send_cmd(OP_TX_BYTE, 8'h00, 1'b0);
		send_cmd(OP_TICK, 8'h00, 1'b0);
		send_cmd(OP_RX_BYTE, 8'hFF, 1'b0);
		send_cmd(OP_RX_ERR, 8'h00, 1'b0);
		send_cmd(OP_TX_BYTE, 8'hFF, 1'b1);

		// T1.5 below T3.5: traffic in control-wait, a full frame and an over-long message.
		wait_quiet();
		set_timing(16'd2, 16'd6);
		rx_random(3, 1'b0);
		ticks(2);
		send_cmd(OP_RX_BYTE, 8'hC3, 1'b0);
		send_cmd(OP_TX_BYTE, 8'h81, 1'b1);
		send_cmd(OP_RX_ERR, 8'h00, 1'b0);
		settle();
		rx_random(MAX_FRAME - 2, 1'b0);
		send_cmd(OP_RX_BYTE, 8'h7E, 1'b0);
		settle();
		tx_message(MAX_FRAME - 2, 1'b0);
	endtask

	task automatic random_sequence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			rx_random($urandom_range(2, 10), 1'b0);
		end else if (pick < 55) begin
			rx_random($urandom_range(0, 8), 1'b1);
		end else if (pick < 75) begin
			tx_message($urandom_range(1, 8), 1'b1);
		end else if (pick < 85) begin
			rx_raw($urandom_range(1, 5));
			send_cmd(OP_RX_ERR, 8'($urandom), 1'($urandom));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				send_cmd(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
			end
		end
		// Mostly close the frame cleanly; sometimes leave it open for the next bytes.
		if ($urandom_range(0, 4) != 0) settle();
		else ticks($urandom_range(0, 4));
	endtask

	task automatic run_random();
		int unsigned base;
		int          phase;
		base = n_active;
		phase = 0;
		while (n_active - base < RANDOM_ITEMS) begin
			wait_quiet();
			set_timing(16'($urandom_range(1, 10)), 16'($urandom_range(1, 14)));
			steady <= (phase == 2);
			if (phase == 1) begin
				// The result side holds off while a long message keeps arriving.
				hold_req <= hold_req + 1;
				tx_message(12, 1'b1);
			end
			repeat (8) random_sequence();
			settle();
			phase++;
		end
		steady <= 1'b0;
	endtask

	initial begin
		cmd.valid <= 1'b0;
		cmd.op <= OP_TICK;
		cmd.byte_value <= 8'h00;
		cmd.end_of_message <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_T15;
		cfg.data <= 16'h0000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_quiet();
		$display("Drove %0d command words (%0d other than ticks);",
			n_items, n_active);
		$display("frames ok %0d, short %0d, bad CRC %0d; checked %0d result words,",
			sb.n_ok, sb.n_short, sb.n_bad, sb.words_seen);
		$display("%0d messages sent, %0d sends refused, %0d mismatches.",
			sb.n_messages, sb.n_refused, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("modbus_rtu_frame_engine_core test passed");
		end else begin
			$display("modbus_rtu_frame_engine_core test failed");
		end
		$finish;
	end
endmodule
